>>> hdl/base85_decoder_with_checksums_top_assert.svh
// Assertion macros for the base-85 decoder top level.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef BASE85_DECODER_WITH_CHECKSUMS_TOP_ASSERT_SVH
`define BASE85_DECODER_WITH_CHECKSUMS_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B85D_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("b85d same-cycle assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define B85D_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("b85d next-cycle assertion failed");

`endif

>>> hdl/b85d_pkg.sv
// Shared types, character codes and helpers of the base-85 decoder.
// Used by the front, the command queue, the back and the top level.
package b85d_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned BYTES_PER_WORD = 4;

  localparam logic [7:0] CHAR_BANG = 8'h21;  // '!' is digit zero
  localparam logic [7:0] CHAR_TOP  = 8'h75;  // 'u' is digit 84
  localparam logic [7:0] CHAR_Z    = 8'h7A;
  localparam logic [7:0] CHAR_X    = 8'h78;
  localparam logic [7:0] CHAR_NL   = 8'h0A;

  typedef enum logic [1:0] {
    CMD_WORD,
    CMD_ERR,
    CMD_DONE
  } cmd_kind_e;

  // One command from the front to the back.
  typedef struct packed {
    cmd_kind_e   kind;
    logic [31:0] word;
    logic        err;
  } cmd_t;

  // Multiply by 85 with shifts and adds, wrapping at 32 bits.
  function automatic logic [31:0] mul85(input logic [31:0] x);
    logic [31:0] t;
    t = (x << 2) + x;
    t = (t << 2) + x;
    t = (t << 2) + x;
    return t;
  endfunction

endpackage

>>> hdl/b85d_front.sv
// Front part of the base-85 decoder: accepts characters, builds groups and
// the sticky error flag, and issues commands. Depends on b85d_pkg.
module b85d_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  input  logic [7:0]       s_tdata_i,
  output logic             s_tready_o,
  input  logic             full_i,
  output logic             push_o,
  output b85d_pkg::cmd_t   cmd_o
);

  logic [31:0] group_q, group_d;
  logic [2:0]  count_q, count_d;
  logic        err_q, err_d;
  logic        accept;
  logic [31:0] next_val;
  logic        is_digit;

  assign s_tready_o = !full_i;
  assign accept     = s_tvalid_i && !full_i;
  assign is_digit   = (s_tdata_i >= b85d_pkg::CHAR_BANG) && (s_tdata_i <= b85d_pkg::CHAR_TOP);
  assign next_val   = b85d_pkg::mul85(group_q) + {24'd0, s_tdata_i - b85d_pkg::CHAR_BANG};

  always_comb begin
    group_d    = group_q;
    count_d    = count_q;
    err_d      = err_q;
    push_o     = 1'b0;
    cmd_o.kind = b85d_pkg::CMD_ERR;
    cmd_o.word = 32'd0;
    cmd_o.err  = 1'b1;
    if (accept) begin
      priority if (s_tdata_i == b85d_pkg::CHAR_X) begin
        push_o     = 1'b1;
        cmd_o.kind = b85d_pkg::CMD_DONE;
        cmd_o.err  = err_q;
        group_d    = 32'd0;
        count_d    = 3'd0;
        err_d      = 1'b0;
      end else if (err_q) begin
        push_o = 1'b1;
      end else if (s_tdata_i == b85d_pkg::CHAR_NL) begin
        push_o = 1'b0;
      end else if (s_tdata_i == b85d_pkg::CHAR_Z) begin
        push_o = 1'b1;
        if (count_q == 3'd0) begin
          cmd_o.kind = b85d_pkg::CMD_WORD;
          cmd_o.err  = 1'b0;
        end else begin
          err_d = 1'b1;
        end
      end else if (is_digit) begin
        if (count_q < 3'(b85d_pkg::BYTES_PER_WORD)) begin
          group_d = next_val;
          count_d = count_q + 3'd1;
        end else begin
          push_o     = 1'b1;
          cmd_o.kind = b85d_pkg::CMD_WORD;
          cmd_o.word = next_val;
          cmd_o.err  = 1'b0;
          group_d    = 32'd0;
          count_d    = 3'd0;
        end
      end else begin
        push_o = 1'b1;
        err_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= 32'd0;
      count_q <= 3'd0;
      err_q   <= 1'b0;
    end else begin
      group_q <= group_d;
      count_q <= count_d;
      err_q   <= err_d;
    end
  end

endmodule

>>> hdl/b85d_fifo.sv
// Short command queue between the front and the back of the decoder.
// Depends on b85d_pkg for the command type.
module b85d_fifo #(
  parameter int unsigned DEPTH = b85d_pkg::FIFO_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b85d_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output b85d_pkg::cmd_t cmd_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  b85d_pkg::cmd_t  mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

>>> hdl/b85d_back.sv
// Back part of the decoder: expands commands into results, keeps the three
// running checks and drives the output register. Depends on b85d_pkg.
module b85d_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  b85d_pkg::cmd_t cmd_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           m_tvalid_o,
  input  logic           m_tready_i,
  output logic [79:0]    m_tdata_o,
  output logic           m_tlast_o,
  output logic [2:0]     m_tuser_o
);

  localparam logic [1:0] LastByte = 2'(b85d_pkg::BYTES_PER_WORD - 1);

  logic        valid_q;
  logic [1:0]  idx_q, idx_d;
  logic [7:0]  xor_q, xor_d;
  logic [31:0] sum_q, sum_d;
  logic [31:0] rot_q, rot_d;
  logic [7:0]  byte_q, byte_d, oxor_d;
  logic [31:0] osum_d, orot_d;
  logic        has_q, has_d, last_q, last_d, err_q, err_d, done_q, done_d;
  logic        load, take;
  logic [7:0]  sel_byte;

  assign load = !valid_q || m_tready_i;
  assign take = load && !empty_i;

  always_comb begin
    unique case (idx_q)
      2'd0:    sel_byte = cmd_i.word[31:24];
      2'd1:    sel_byte = cmd_i.word[23:16];
      2'd2:    sel_byte = cmd_i.word[15:8];
      default: sel_byte = cmd_i.word[7:0];
    endcase
  end

  always_comb begin
    idx_d  = idx_q;
    xor_d  = xor_q;
    sum_d  = sum_q;
    rot_d  = rot_q;
    byte_d = 8'd0;
    has_d  = 1'b0;
    last_d = 1'b1;
    err_d  = cmd_i.err;
    done_d = 1'b0;
    oxor_d = xor_q;
    osum_d = sum_q;
    orot_d = rot_q;
    pop_o  = 1'b0;
    if (take) begin
      unique case (cmd_i.kind)
        b85d_pkg::CMD_WORD: begin
          byte_d = sel_byte;
          has_d  = 1'b1;
          err_d  = 1'b0;
          xor_d  = xor_q ^ sel_byte;
          sum_d  = sum_q + {24'd0, sel_byte} + 32'd1;
          rot_d  = {rot_q[30:0], rot_q[31]} + {24'd0, sel_byte};
          oxor_d = xor_d;
          osum_d = sum_d;
          orot_d = rot_d;
          last_d = (idx_q == LastByte);
          pop_o  = last_d;
          idx_d  = last_d ? 2'd0 : idx_q + 2'd1;
        end
        b85d_pkg::CMD_DONE: begin
          done_d = 1'b1;
          pop_o  = 1'b1;
          xor_d  = 8'd0;
          sum_d  = 32'd0;
          rot_d  = 32'd0;
        end
        default: begin
          err_d = 1'b1;
          pop_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
      xor_q   <= 8'd0;
      sum_q   <= 32'd0;
      rot_q   <= 32'd0;
    end else begin
      if (load) begin
        valid_q <= !empty_i;
      end
      idx_q <= idx_d;
      xor_q <= xor_d;
      sum_q <= sum_d;
      rot_q <= rot_d;
    end
  end

  // Payload of the output register.
  logic [7:0]  oxor_q;
  logic [31:0] osum_q, orot_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= byte_d;
      has_q  <= has_d;
      last_q <= last_d;
      err_q  <= err_d;
      done_q <= done_d;
      oxor_q <= oxor_d;
      osum_q <= osum_d;
      orot_q <= orot_d;
    end
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = {orot_q, osum_q, oxor_q, byte_q};
  assign m_tlast_o  = last_q;
  assign m_tuser_o  = {done_q, err_q, has_q};

endmodule

>>> hdl/base85_decoder_with_checksums_top.sv
// Base-85 decoder with running checks: one character per cycle in while the queue
// has room. A group or a 'z' gives four byte results, which leave one at a time
// through the single output register.
// Reset: rst_ni clears group, checks, error flag, queue and output valid at once.
module base85_decoder_with_checksums_top #(
  parameter int unsigned FIFO_DEPTH = b85d_pkg::FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream. tdata fields from bit 0 up: char_code[7:0].
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,
  // Output stream. tdata fields from bit 0 up: data_byte[7:0], check_xor[15:8],
  // check_sum[47:16], check_rotate[79:48].
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  // tuser fields from bit 0 up: has_data[0], error[1], done_res[2].
  output logic [2:0]  m_axis_tuser_o
);

  // The front classifies each character in the cycle it is accepted and keeps
  // the partial group and the sticky error flag. It issues at most one
  // command per character: a full word (also the four zeros of 'z'), an
  // error result, or the end result of 'x'.
  b85d_pkg::cmd_t push_cmd, head_cmd;
  logic           push, pop, empty, full;

  b85d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tready_o (s_axis_tready_o),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // The queue lets the front keep taking characters while the back sends the
  // four bytes of a word one by one or waits on a stalled consumer.
  b85d_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (empty),
    .full_o  (full)
  );

  // The back owns the running checks, so each result carries the checks in
  // effect after its own update, and the end result clears them.
  b85d_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (head_cmd),
    .empty_i    (empty),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tlast_o  (m_axis_tlast_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

`include "base85_decoder_with_checksums_top_assert.svh"

  // A data result is never also an error or end result.
  `B85D_ASSERT_NOW(a_data_excl, m_axis_tvalid_o && m_axis_tuser_o[0], !m_axis_tuser_o[1] && !m_axis_tuser_o[2])
  // Error and end results stand alone and always close their transaction group.
  `B85D_ASSERT_NOW(a_flag_last, m_axis_tvalid_o && !m_axis_tuser_o[0], m_axis_tlast_o)
  // A popped command always finds room in the output register, so a pop is
  // followed by a valid result.
  `B85D_ASSERT_NEXT(a_pop_valid, pop, m_axis_tvalid_o)

endmodule

>>> tb/b85d_checker.sv
`timescale 1ns / 1ps
// Checker for the base-85 decoder. It watches both streams, predicts the output
// transactions from the accepted characters and compares them. Needs b85d_pkg.
module b85d_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_data_i,      // char_code[7:0]
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [79:0] out_data_i,     // data_byte, check_xor, check_sum, check_rotate
  input  logic        out_last_i,
  input  logic [2:0]  out_user_i,     // has_data, error, done_res
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  localparam logic [31:0] RADIX = 32'd85;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        has_data;
    logic        last;
    logic        err;
    logic        done_res;
    logic [7:0]  chk_xor;
    logic [31:0] chk_sum;
    logic [31:0] chk_rot;
  } beat_t;

  beat_t       decoded_q[$];
  logic [31:0] grp_val  = '0;
  logic [2:0]  grp_cnt  = '0;
  logic [7:0]  xor_acc  = '0;
  logic [31:0] sum_acc  = '0;
  logic [31:0] rot_acc  = '0;
  logic        err_seen = 1'b0;

  task automatic clear_state();
    grp_val  = '0;
    grp_cnt  = '0;
    xor_acc  = '0;
    sum_acc  = '0;
    rot_acc  = '0;
    err_seen = 1'b0;
  endtask

  // A decoded byte first folds into all three running checks.
  task automatic push_byte(input logic [7:0] b, input logic is_last);
    xor_acc = xor_acc ^ b;
    sum_acc = sum_acc + {24'd0, b} + 32'd1;
    rot_acc = {rot_acc[30:0], rot_acc[31]} + {24'd0, b};
    decoded_q.push_back('{b, 1'b1, is_last, 1'b0, 1'b0, xor_acc, sum_acc, rot_acc});
  endtask

  // Error and end results carry no byte and are always the last of their item.
  task automatic push_status(input logic err, input logic done);
    decoded_q.push_back('{8'd0, 1'b0, 1'b1, err, done, xor_acc, sum_acc, rot_acc});
  endtask

  task automatic decode_char(input logic [7:0] c);
    logic [31:0] word;
    if (c == b85d_pkg::CHAR_X) begin
      push_status(err_seen, 1'b1);
      clear_state();
    end else if (err_seen) begin
      push_status(1'b1, 1'b0);
    end else if (c == b85d_pkg::CHAR_NL) begin
      // Ignored outside an error.
    end else if (c == b85d_pkg::CHAR_Z) begin
      if (grp_cnt == 3'd0) begin
        for (int i = 0; i < 4; i++) push_byte(8'd0, i == 3);
      end else begin
        err_seen = 1'b1;
        push_status(1'b1, 1'b0);
      end
    end else if (c >= b85d_pkg::CHAR_BANG && c <= b85d_pkg::CHAR_TOP) begin
      word = grp_val * RADIX + {24'd0, c - b85d_pkg::CHAR_BANG};
      if (grp_cnt < 3'd4) begin
        grp_val = word;
        grp_cnt = grp_cnt + 3'd1;
      end else begin
        push_byte(word[31:24], 1'b0);
        push_byte(word[23:16], 1'b0);
        push_byte(word[15:8], 1'b0);
        push_byte(word[7:0], 1'b1);
        grp_val = '0;
        grp_cnt = '0;
      end
    end else begin
      err_seen = 1'b1;
      push_status(1'b1, 1'b0);
    end
  endtask

  task automatic report_beat(input string what, input beat_t want, input beat_t got);
    if (fail_count_o < MAX_REPORTS) begin
      $display("[%0t] %s", $realtime, what);
      $display("  want byte=%02h has=%b last=%b err=%b done=%b xor=%02h sum=%08h rot=%08h",
               want.data_byte, want.has_data, want.last, want.err, want.done_res,
               want.chk_xor, want.chk_sum, want.chk_rot);
      $display("  got  byte=%02h has=%b last=%b err=%b done=%b xor=%02h sum=%08h rot=%08h",
               got.data_byte, got.has_data, got.last, got.err, got.done_res,
               got.chk_xor, got.chk_sum, got.chk_rot);
    end
    fail_count_o = fail_count_o + 1;
  endtask

  always @(posedge clk_i) begin : watch
    beat_t got;
    beat_t want;
    if (!rst_ni) begin
      clear_state();
      decoded_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) decode_char(in_data_i);
      if (out_valid_i && out_ready_i) begin
        got = '{out_data_i[7:0], out_user_i[0], out_last_i, out_user_i[1], out_user_i[2],
                out_data_i[15:8], out_data_i[47:16], out_data_i[79:48]};
        if (decoded_q.size() == 0) begin
          report_beat("output transaction with no result expected", '0, got);
        end else begin
          want = decoded_q.pop_front();
          checked_o = checked_o + 1;
          if (got.data_byte !== want.data_byte || got.has_data !== want.has_data ||
              got.last !== want.last || got.err !== want.err ||
              got.done_res !== want.done_res || got.chk_xor !== want.chk_xor ||
              got.chk_sum !== want.chk_sum || got.chk_rot !== want.chk_rot)
            report_beat("output transaction mismatch", want, got);
        end
      end
    end
    pending_o = decoded_q.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Top of the base-85 decoder testbench: makes the character stimulus, throttles
// the output stream and gives the verdict. Needs b85d_pkg, the decoder top level
// and b85d_checker.
module tb;

  localparam int unsigned RANDOM_ITEMS   = 170;
  localparam int unsigned DIRECTED_ITEMS = 28;
  localparam int unsigned LONG_HOLD      = 80;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned CYCLE_LIMIT    = 200000;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_valid  = 1'b0;
  logic [7:0]  s_data   = '0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready  = 1'b0;
  logic [79:0] m_data;
  logic        m_last;
  logic [2:0]  m_user;

  // s_fire holds whether the input stream moved a transaction at the last
  // rising edge, so the sender can look at it safely at the falling edge.
  logic        s_fire   = 1'b0;
  logic        idle_en  = 1'b1;
  logic        nl_mix   = 1'b0;
  logic        hold_req = 1'b0;

  int unsigned items_sent = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  always #5 clk = ~clk;

  base85_decoder_with_checksums_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .m_axis_tuser_o  (m_user)
  );

  b85d_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (s_valid),
    .in_ready_i   (s_ready),
    .in_data_i    (s_data),
    .out_valid_i  (m_valid),
    .out_ready_i  (m_ready),
    .out_data_i   (m_data),
    .out_last_i   (m_last),
    .out_user_i   (m_user),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always @(posedge clk) s_fire <= s_valid && s_ready;

  // Receiver. Normally ready, with random stall bursts while idling is on.
  // When the stimulus asks for it, the receiver holds off for a long stretch
  // that it counts itself, so that the decoder's queue fills up and its input
  // stream stalls while the sender keeps offering characters.
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
        m_ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        m_ready <= 1'b1;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a correct run ends far below this many cycles.
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding.", cycle_cnt, pending);
    $display("FAILURE");
    $finish;
  end

  // Offers one character and returns at the falling edge after the rising edge
  // that took it. Entry is always at a falling edge, so a back-to-back offer
  // only updates the data and never drops and re-raises tvalid in one step.
  task automatic send_char(input logic [7:0] c);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= c;
    do @(negedge clk); while (!s_fire);
    items_sent++;
  endtask

  // Sends the five digits that encode a 32-bit word, most significant first,
  // with newlines mixed in between digits when that is enabled.
  task automatic send_group(input logic [31:0] word);
    longint unsigned rest;
    logic [7:0]      digit [5];
    rest = word;
    for (int i = 4; i >= 0; i--) begin
      digit[i] = 8'(rest % 85);
      rest     = rest / 85;
    end
    for (int i = 0; i < 5; i++) begin
      if (i > 0 && nl_mix && $urandom_range(0, 5) == 0) send_char(b85d_pkg::CHAR_NL);
      send_char(b85d_pkg::CHAR_BANG + digit[i]);
    end
  endtask

  // Raw digits, with no word behind them. With high_only set the digits sit
  // near the top of the alphabet, so a full group can overflow 32 bits and wrap.
  task automatic send_digits(input int unsigned count, input bit high_only);
    for (int i = 0; i < count; i++)
      send_char(b85d_pkg::CHAR_BANG +
                8'(high_only ? $urandom_range(80, 84) : $urandom_range(0, 84)));
  endtask

  // Drops tvalid and waits until every predicted result has been checked.
  task automatic wait_drained();
    s_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Random traffic: mostly well-formed groups and zero runs, with end marks
  // often enough that an error does not stick around for long, and a share of
  // broken groups, misplaced z characters and arbitrary codes.
  task automatic random_burst(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 32) begin
        send_group($urandom());
      end else if (pick < 46) begin
        send_digits(5, $urandom_range(0, 1));
      end else if (pick < 52) begin
        send_group($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
      end else if (pick < 64) begin
        send_char(b85d_pkg::CHAR_Z);
      end else if (pick < 73) begin
        send_char(b85d_pkg::CHAR_X);
      end else if (pick < 81) begin
        // Broken group: a few digits, then a z inside the group or any code.
        send_digits($urandom_range(1, 4), 1'b0);
        send_char($urandom_range(0, 1) ? b85d_pkg::CHAR_Z : 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) send_char(b85d_pkg::CHAR_X);
      end else if (pick < 91) begin
        send_char(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) send_char(b85d_pkg::CHAR_X);
      end else begin
        send_char(b85d_pkg::CHAR_NL);
      end
    end
  endtask

  initial begin : stimulus
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. An all-zero group, a z run, a plain newline, the group
    // for the largest word and an overflowing group, then an end mark that
    // drops an unfinished group.
    send_group(32'h0);
    send_char(b85d_pkg::CHAR_Z);
    send_char(b85d_pkg::CHAR_NL);
    send_group(32'hFFFF_FFFF);
    repeat (5) send_char(b85d_pkg::CHAR_TOP);
    send_char(b85d_pkg::CHAR_BANG);
    send_char(b85d_pkg::CHAR_X);
    // A z inside a group raises the sticky error; a newline, a digit and the
    // top code then each give an error result until the end mark clears it.
    send_char(b85d_pkg::CHAR_BANG);
    send_char(b85d_pkg::CHAR_BANG);
    send_char(b85d_pkg::CHAR_Z);
    send_char(b85d_pkg::CHAR_NL);
    send_char(b85d_pkg::CHAR_BANG);
    send_char(8'hFF);
    send_char(b85d_pkg::CHAR_X);
    // The lowest code is invalid as well.
    send_char(8'h00);
    send_char(b85d_pkg::CHAR_X);
    wait_drained();

    // Random part with idling on both sides.
    nl_mix = 1'b1;
    random_burst(60);

    // Long receiver hold-off while the sender keeps pushing z runs, each of
    // which expands to four output transactions.
    send_char(b85d_pkg::CHAR_X);
    hold_req = 1'b1;
    repeat (12) send_char(b85d_pkg::CHAR_Z);
    wait_drained();

    random_burst(50);

    // The closing stretch runs with no idling on either side.
    idle_en = 1'b0;
    random_burst(RANDOM_ITEMS - DIRECTED_ITEMS - 60 - 13 - 50);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d characters and checked %0d output transactions.", items_sent, checked);
    $display("Covered groups, z runs, end marks, bad codes, a long stall and drain pauses.");
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
